// ===== design/tac_pkg.sv =====
// shared types, constants and mode codes for the temperature alarm controller
// no dependencies; imported by every module of the block

package tac_pkg;

  localparam int TAC_ADC_BITS    = 10;
  localparam int TAC_QUEUE_DEPTH = 2;

  localparam int TAC_TEMP_W  = 12;
  localparam int TAC_DIGIT_W = 4;
  localparam int TAC_MODE_W  = 3;
  localparam int TAC_SHOWN_W = 10;

  localparam logic [TAC_TEMP_W-1:0] TAC_THRESHOLD_RST = 12'd800;
  localparam logic [TAC_TEMP_W-1:0] TAC_DISPLAY_MAX   = 12'd999;

  // millivolts: adc * 3.1672, multiplier rounded up so the floor is exact for 16-bit samples
  localparam int TAC_MV_MULT  = 425094389;
  localparam int TAC_MV_SHIFT = 27;

  // tenths = floor((TAC_N_BIAS - 144*mv) / 49), negative numerator clamps to zero
  localparam int TAC_N_W      = 18;
  localparam int TAC_N_BIAS   = 166502;
  localparam int TAC_Q_MULT   = 684785;
  localparam int TAC_Q_MULT_W = 20;
  localparam int TAC_Q_SHIFT  = 25;

  localparam logic [TAC_MODE_W-1:0] TAC_MODE_START    = 3'd0;
  localparam logic [TAC_MODE_W-1:0] TAC_MODE_DISARMED = 3'd1;
  localparam logic [TAC_MODE_W-1:0] TAC_MODE_WAIT1    = 3'd2;
  localparam logic [TAC_MODE_W-1:0] TAC_MODE_ARMED    = 3'd3;
  localparam logic [TAC_MODE_W-1:0] TAC_MODE_ALARM    = 3'd4;
  localparam logic [TAC_MODE_W-1:0] TAC_MODE_WAIT2    = 3'd5;

  // converted request handed from the front end to the back end
  typedef struct packed {
    logic [TAC_TEMP_W-1:0] temp;
    logic                  released;
  } tac_item_t;

endpackage

// ===== design/tac_front.sv =====
// front end: takes a sample request and converts it to tenths of a degree F
// depends on tac_pkg; feeds tac_queue

module tac_front import tac_pkg::*; #(
  parameter int ADC_BITS = TAC_ADC_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ADC_BITS-1:0] in_adc_sample,
  input  logic                in_button_level,
  output logic                push_valid,
  input  logic                push_ready,
  output tac_item_t           push_item
);

  localparam int MV_W   = ADC_BITS + 2;
  localparam int MVP_W  = ADC_BITS + TAC_MV_SHIFT + 2;
  localparam int M144_W = MV_W + 8;
  localparam int QP_W   = TAC_N_W + TAC_Q_MULT_W;

  logic [2:0]            stg_v_r, stg_v_nxt;
  logic [ADC_BITS-1:0]   adc_r;
  logic                  rel_r;
  logic [MV_W-1:0]       mv_r;
  logic [TAC_N_W-1:0]    n_r;
  logic                  neg_r;

  logic                  accept;
  logic [MVP_W-1:0]      mv_prod;
  logic [M144_W-1:0]     mv144;
  logic [QP_W-1:0]       q_prod;
  logic [TAC_TEMP_W-1:0] temp;

  // one request in flight: stalled from accept until its push
  assign in_stall = |stg_v_r;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    stg_v_nxt[0] = accept;
    stg_v_nxt[1] = stg_v_r[0];
    stg_v_nxt[2] = stg_v_r[1] | (stg_v_r[2] & ~push_ready);
  end

  always_comb begin
    mv_prod = MVP_W'(adc_r) * MVP_W'(TAC_MV_MULT);
    mv144   = (M144_W'(mv_r) << 7) + (M144_W'(mv_r) << 4);
    q_prod  = QP_W'(n_r) * QP_W'(TAC_Q_MULT);
    temp    = neg_r ? '0 : q_prod[TAC_Q_SHIFT +: TAC_TEMP_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= '0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      adc_r <= in_adc_sample;
      rel_r <= in_button_level;
    end
    if (stg_v_r[0]) begin
      mv_r <= mv_prod[TAC_MV_SHIFT +: MV_W];
    end
    if (stg_v_r[1]) begin
      neg_r <= mv144 > M144_W'(TAC_N_BIAS);
      n_r   <= TAC_N_W'(TAC_N_BIAS) - mv144[TAC_N_W-1:0];
    end
  end

  assign push_valid         = stg_v_r[2];
  assign push_item.temp     = temp;
  assign push_item.released = rel_r;

endmodule

// ===== design/tac_queue.sv =====
// small fifo between the front and back ends
// depends on tac_pkg only for the default depth; generic width and depth (depth >= 2)

module tac_queue import tac_pkg::*; #(
  parameter int WIDTH = 13,
  parameter int DEPTH = TAC_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = cnt_r != CNT_W'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/tac_back.sv =====
// back end: arm/alarm state machine, display saturation and bcd split
// depends on tac_pkg; drains tac_queue and drives the result channel

module tac_back import tac_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [TAC_TEMP_W-1:0]  threshold,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  tac_item_t              pop_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [TAC_MODE_W-1:0]  out_mode,
  output logic                   out_alarm_pin,
  output logic                   out_display_valid,
  output logic [TAC_TEMP_W-1:0]  out_temp_tenths,
  output logic [TAC_DIGIT_W-1:0] out_tens_digit,
  output logic [TAC_DIGIT_W-1:0] out_ones_digit,
  output logic [TAC_DIGIT_W-1:0] out_tenths_digit
);

  typedef enum logic [5:0] {
    ST_START    = 6'b000001,
    ST_DISARMED = 6'b000010,
    ST_WAIT1    = 6'b000100,
    ST_ARMED    = 6'b001000,
    ST_ALARM    = 6'b010000,
    ST_WAIT2    = 6'b100000
  } tac_state_t;

  tac_state_t st_r, st_nxt;

  logic b1_v_r, b1_v_nxt;
  logic b2_v_r, b2_v_nxt;
  logic out_v_r, out_v_nxt;
  logic out_free, b2_free, b1_free;
  logic load_b1, load_b2, load_out;

  logic [TAC_MODE_W-1:0]  mode_nxt;
  logic                   alarm_nxt, disp_nxt;
  logic [TAC_SHOWN_W-1:0] shown;
  logic [15:0]            h_prod;
  logic [TAC_SHOWN_W-1:0] rem_full;
  logic [14:0]            d_prod;
  logic [6:0]             d_times10;

  // stage 1 registers
  logic [TAC_MODE_W-1:0]  b1_mode_r;
  logic                   b1_alarm_r, b1_disp_r;
  logic [TAC_TEMP_W-1:0]  b1_temp_r;
  logic [TAC_SHOWN_W-1:0] b1_shown_r;
  logic [TAC_DIGIT_W-1:0] b1_hund_r;
  // stage 2 registers
  logic [TAC_MODE_W-1:0]  b2_mode_r;
  logic                   b2_alarm_r, b2_disp_r;
  logic [TAC_TEMP_W-1:0]  b2_temp_r;
  logic [TAC_DIGIT_W-1:0] b2_hund_r;
  logic [6:0]             b2_rem_r;

  assign out_free = ~out_v_r | ~out_stall;
  assign b2_free  = ~b2_v_r | out_free;
  assign b1_free  = ~b1_v_r | b2_free;
  assign load_out = b2_v_r & out_free;
  assign load_b2  = b1_v_r & b2_free;
  assign load_b1  = pop_valid & b1_free;
  assign pop_ready = b1_free;

  always_comb begin
    b1_v_nxt  = load_b1 | (b1_v_r & ~b2_free);
    b2_v_nxt  = load_b2 | (b2_v_r & ~out_free);
    out_v_nxt = load_out | (out_v_r & out_stall);
  end

  always_comb begin
    case (st_r)
      ST_DISARMED: st_nxt = pop_item.released ? ST_DISARMED : ST_WAIT1;
      ST_WAIT1:    st_nxt = pop_item.released ? ST_ARMED : ST_WAIT1;
      ST_ARMED:    st_nxt = (pop_item.temp >= threshold) ? ST_ALARM : ST_ARMED;
      ST_ALARM:    st_nxt = pop_item.released ? ST_ALARM : ST_WAIT2;
      ST_WAIT2:    st_nxt = pop_item.released ? ST_DISARMED : ST_WAIT2;
      default:     st_nxt = ST_DISARMED;
    endcase
  end

  always_comb begin
    case (st_nxt)
      ST_DISARMED: mode_nxt = TAC_MODE_DISARMED;
      ST_WAIT1:    mode_nxt = TAC_MODE_WAIT1;
      ST_ARMED:    mode_nxt = TAC_MODE_ARMED;
      ST_ALARM:    mode_nxt = TAC_MODE_ALARM;
      ST_WAIT2:    mode_nxt = TAC_MODE_WAIT2;
      default:     mode_nxt = TAC_MODE_START;
    endcase
    alarm_nxt = (st_nxt == ST_ALARM) | (st_nxt == ST_WAIT2);
    disp_nxt  = (st_nxt == ST_DISARMED) | (st_nxt == ST_ARMED) | (st_nxt == ST_ALARM);
  end

  // hundreds = x*41 >> 12, tens = r*205 >> 11, both exact over their ranges
  always_comb begin
    shown     = (pop_item.temp > TAC_DISPLAY_MAX) ? TAC_DISPLAY_MAX[TAC_SHOWN_W-1:0]
                                                  : pop_item.temp[TAC_SHOWN_W-1:0];
    h_prod    = 16'(shown) * 16'd41;
    rem_full  = b1_shown_r - TAC_SHOWN_W'(b1_hund_r) * 10'd100;
    d_prod    = 15'(b2_rem_r) * 15'd205;
    d_times10 = 7'(d_prod[14:11]) * 7'd10;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_START;
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (load_b1) begin
        st_r <= st_nxt;
      end
      b1_v_r  <= b1_v_nxt;
      b2_v_r  <= b2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_b1) begin
      b1_mode_r  <= mode_nxt;
      b1_alarm_r <= alarm_nxt;
      b1_disp_r  <= disp_nxt;
      b1_temp_r  <= pop_item.temp;
      b1_shown_r <= shown;
      b1_hund_r  <= h_prod[15:12];
    end
    if (load_b2) begin
      b2_mode_r  <= b1_mode_r;
      b2_alarm_r <= b1_alarm_r;
      b2_disp_r  <= b1_disp_r;
      b2_temp_r  <= b1_temp_r;
      b2_hund_r  <= b1_hund_r;
      b2_rem_r   <= rem_full[6:0];
    end
    if (load_out) begin
      out_mode          <= b2_mode_r;
      out_alarm_pin     <= b2_alarm_r;
      out_display_valid <= b2_disp_r;
      out_temp_tenths   <= b2_temp_r;
      out_tens_digit    <= b2_hund_r;
      out_ones_digit    <= d_prod[14:11];
      out_tenths_digit  <= 4'(b2_rem_r - d_times10);
    end
  end

  assign out_valid = out_v_r;

endmodule

// ===== design/temperature_alarm_controller_core.sv =====
// Temperature alarm controller. Each input request carries one ADC sample and
// the active-low button level; each yields exactly one result request with the
// new mode, alarm pin, display-valid flag, temperature in tenths of deg F and
// three BCD display digits (display saturated to 99.9).
// Channels: in_* and out_* use valid/stall, a request moves on an edge with
// valid high and stall low. cfg_* writes the alarm threshold (valid/ready,
// ready always high); write it only while no request is in flight.
// The front end takes a new request only once the last one has been pushed: its
// three-step conversion (millivolt multiply, numerator, divide-by-49 multiply)
// holds one request at a time. The back end is a 3-stage pipeline behind a
// 2-entry queue.
// Reset (rst_n low, synchronous): mode returns to start, queue and pipeline
// empty, threshold 80.0 deg F.
// A stalled result holds in the output register; the queue then fills and the
// front end raises in_stall until space frees up.
// Depends on tac_pkg, tac_front, tac_queue, tac_back.

module temperature_alarm_controller_core import tac_pkg::*; #(
  parameter int ADC_BITS    = TAC_ADC_BITS,
  parameter int QUEUE_DEPTH = TAC_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [ADC_BITS-1:0]    in_adc_sample,
  input  logic                   in_button_level,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [TAC_MODE_W-1:0]  out_mode,
  output logic                   out_alarm_pin,
  output logic                   out_display_valid,
  output logic [TAC_TEMP_W-1:0]  out_temp_tenths,
  output logic [TAC_DIGIT_W-1:0] out_tens_digit,
  output logic [TAC_DIGIT_W-1:0] out_ones_digit,
  output logic [TAC_DIGIT_W-1:0] out_tenths_digit,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [TAC_TEMP_W-1:0]  cfg_alarm_threshold_tenths
);

  localparam int ITEM_W = $bits(tac_item_t);

  logic [TAC_TEMP_W-1:0] threshold_r;
  logic                  push_valid, push_ready;
  tac_item_t             push_item;
  logic                  pop_valid, pop_ready;
  tac_item_t             pop_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= TAC_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      threshold_r <= cfg_alarm_threshold_tenths;
    end
  end

  tac_front #(
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_adc_sample   (in_adc_sample),
    .in_button_level (in_button_level),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_item       (push_item)
  );

  tac_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_item)
  );

  tac_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .threshold         (threshold_r),
    .pop_valid         (pop_valid),
    .pop_ready         (pop_ready),
    .pop_item          (pop_item),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_mode          (out_mode),
    .out_alarm_pin     (out_alarm_pin),
    .out_display_valid (out_display_valid),
    .out_temp_tenths   (out_temp_tenths),
    .out_tens_digit    (out_tens_digit),
    .out_ones_digit    (out_ones_digit),
    .out_tenths_digit  (out_tenths_digit)
  );

  // alarm pin follows the reported mode
  a_alarm_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_alarm_pin == ((out_mode == TAC_MODE_ALARM) ||
                                     (out_mode == TAC_MODE_WAIT2))))
    else $error("alarm pin disagrees with mode");

  // digits recompose the temperature whenever it is at or below the display limit
  a_digits_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_temp_tenths <= TAC_DISPLAY_MAX)) |->
      ((TAC_TEMP_W'(out_tens_digit) * 12'd100 + TAC_TEMP_W'(out_ones_digit) * 12'd10 +
        TAC_TEMP_W'(out_tenths_digit)) == out_temp_tenths))
    else $error("bcd digits do not match temperature");

  // display saturates at 99.9 for hot readings
  a_digits_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_temp_tenths > TAC_DISPLAY_MAX)) |->
      ((out_tens_digit == 4'd9) && (out_ones_digit == 4'd9) && (out_tenths_digit == 4'd9)))
    else $error("display not saturated");

  // the front end never offers a request the queue cannot take without holding it
  a_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && !push_ready) |=> (push_valid && $stable(push_item)))
    else $error("front end dropped a blocked request");

endmodule

// ===== sim/temperature_alarm_controller_core_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for temperature_alarm_controller_core: directed edge cases,
// then random samples with random sender gaps and receiver stalls across threshold settings
// depends on tac_pkg and the design sources under design/

module temperature_alarm_controller_core_tb;
  import tac_pkg::*;

  localparam int ADC_W        = TAC_ADC_BITS;
  localparam int ADC_MAX      = (1 << ADC_W) - 1;
  localparam int RANDOM_ITEMS = 1450;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE       = 20;

  typedef struct packed {
    logic [TAC_MODE_W-1:0]  mode;
    logic                   alarm_pin;
    logic                   display_valid;
    logic [TAC_TEMP_W-1:0]  temp_tenths;
    logic [TAC_DIGIT_W-1:0] tens;
    logic [TAC_DIGIT_W-1:0] ones;
    logic [TAC_DIGIT_W-1:0] tenths;
  } alarm_report_t;

  class alarm_tracker;
    logic [TAC_MODE_W-1:0] mode      = TAC_MODE_START;
    logic [TAC_TEMP_W-1:0] threshold = TAC_THRESHOLD_RST;
    alarm_report_t pending[$];
    int errors          = 0;
    int reports_checked = 0;
    int alarms_raised   = 0;
    int saturated       = 0;
    int clamped_cold    = 0;

    function logic [TAC_TEMP_W-1:0] tenths_of_adc(logic [ADC_W-1:0] adc);
      longint millivolts, numer, quot, t;
      millivolts = (longint'(adc) * 31672) / 10000;
      numer = (8379 - 8 * millivolts) * 18;
      // cold readings give a negative numerator, floor goes toward minus infinity
      if (numer >= 0) begin
        quot = numer / 49;
      end else begin
        quot = -((-numer + 48) / 49);
      end
      t = 320 + quot;
      if (t < 0) t = 0;
      if (t > 4095) t = 4095;
      return t[TAC_TEMP_W-1:0];
    endfunction

    function void note_sample(logic [ADC_W-1:0] adc, logic released);
      alarm_report_t r;
      logic [TAC_TEMP_W-1:0] shown;
      r.temp_tenths = tenths_of_adc(adc);
      case (mode)
        TAC_MODE_DISARMED: mode = released ? TAC_MODE_DISARMED : TAC_MODE_WAIT1;
        TAC_MODE_WAIT1:    mode = released ? TAC_MODE_ARMED : TAC_MODE_WAIT1;
        TAC_MODE_ARMED: begin
          if (r.temp_tenths >= threshold) begin
            mode = TAC_MODE_ALARM;
            alarms_raised++;
          end
        end
        TAC_MODE_ALARM:    mode = released ? TAC_MODE_ALARM : TAC_MODE_WAIT2;
        TAC_MODE_WAIT2:    mode = released ? TAC_MODE_DISARMED : TAC_MODE_WAIT2;
        default:           mode = TAC_MODE_DISARMED;
      endcase
      shown = (r.temp_tenths > TAC_DISPLAY_MAX) ? TAC_DISPLAY_MAX : r.temp_tenths;
      if (r.temp_tenths > TAC_DISPLAY_MAX) saturated++;
      if (r.temp_tenths == 0) clamped_cold++;
      r.mode          = mode;
      r.alarm_pin     = (mode == TAC_MODE_ALARM) || (mode == TAC_MODE_WAIT2);
      r.display_valid = (mode == TAC_MODE_DISARMED) || (mode == TAC_MODE_ARMED) ||
                        (mode == TAC_MODE_ALARM);
      r.tens          = 4'(shown / 100);
      r.ones          = 4'((shown / 10) % 10);
      r.tenths        = 4'(shown % 10);
      pending.push_back(r);
    endfunction

    function void compare(string fld, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", fld, want, got);
        errors++;
      end
    endfunction

    function void check_report(alarm_report_t got);
      alarm_report_t want;
      if (pending.size() == 0) begin
        $error("result with no request outstanding: mode %0d temp %0d",
               got.mode, got.temp_tenths);
        errors++;
        return;
      end
      want = pending.pop_front();
      reports_checked++;
      compare("mode", 16'(want.mode), 16'(got.mode));
      compare("alarm_pin", 16'(want.alarm_pin), 16'(got.alarm_pin));
      compare("display_valid", 16'(want.display_valid), 16'(got.display_valid));
      compare("temp_tenths", 16'(want.temp_tenths), 16'(got.temp_tenths));
      compare("tens_digit", 16'(want.tens), 16'(got.tens));
      compare("ones_digit", 16'(want.ones), 16'(got.ones));
      compare("tenths_digit", 16'(want.tenths), 16'(got.tenths));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [ADC_W-1:0]       in_adc_sample = '0;
  logic                   in_button_level = 1'b1;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [TAC_MODE_W-1:0]  out_mode;
  logic                   out_alarm_pin;
  logic                   out_display_valid;
  logic [TAC_TEMP_W-1:0]  out_temp_tenths;
  logic [TAC_DIGIT_W-1:0] out_tens_digit;
  logic [TAC_DIGIT_W-1:0] out_ones_digit;
  logic [TAC_DIGIT_W-1:0] out_tenths_digit;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [TAC_TEMP_W-1:0]  cfg_alarm_threshold_tenths = '0;

  alarm_tracker tracker = new();
  int samples_taken      = 0;
  int thresholds_written = 0;
  int cycle_count        = 0;
  int unsigned stall_tick = 0;
  int stall_style         = 0;

  temperature_alarm_controller_core dut (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .in_valid                   (in_valid),
    .in_stall                   (in_stall),
    .in_adc_sample              (in_adc_sample),
    .in_button_level            (in_button_level),
    .out_valid                  (out_valid),
    .out_stall                  (out_stall),
    .out_mode                   (out_mode),
    .out_alarm_pin              (out_alarm_pin),
    .out_display_valid          (out_display_valid),
    .out_temp_tenths            (out_temp_tenths),
    .out_tens_digit             (out_tens_digit),
    .out_ones_digit             (out_ones_digit),
    .out_tenths_digit           (out_tenths_digit),
    .cfg_valid                  (cfg_valid),
    .cfg_ready                  (cfg_ready),
    .cfg_alarm_threshold_tenths (cfg_alarm_threshold_tenths)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // handshakes are observed at the rising edge only
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        tracker.note_sample(in_adc_sample, in_button_level);
        samples_taken++;
      end
      if (out_valid && !out_stall) begin
        tracker.check_report(alarm_report_t'{out_mode, out_alarm_pin, out_display_valid,
                                             out_temp_tenths, out_tens_digit,
                                             out_ones_digit, out_tenths_digit});
      end
      if (cfg_valid && cfg_ready) begin
        tracker.threshold = cfg_alarm_threshold_tenths;
        thresholds_written++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver backpressure: free flow, light, heavy, and long periodic stalls
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 300 == 0) stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_tick % 64) >= 40;
    endcase
  end

  task automatic send_sample(input logic [ADC_W-1:0] adc, input logic btn);
    int target;
    target = samples_taken + 1;
    in_valid        <= 1'b1;
    in_adc_sample   <= adc;
    in_button_level <= btn;
    do @(negedge clk); while (samples_taken != target);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) begin
      in_adc_sample   <= ADC_W'($urandom);
      in_button_level <= 1'($urandom);
      @(negedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (tracker.pending.size() != 0);
  endtask

  task automatic write_threshold(input logic [TAC_TEMP_W-1:0] value);
    int target;
    target = thresholds_written + 1;
    cfg_valid                  <= 1'b1;
    cfg_alarm_threshold_tenths <= value;
    do @(negedge clk); while (thresholds_written != target);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_directed();
    int hot_edge, zero_edge;
    hot_edge  = -1;
    zero_edge = -1;
    // first samples that leave display saturation and that clamp to zero
    for (int a = 0; a <= ADC_MAX; a++) begin
      if (hot_edge < 0 && tracker.tenths_of_adc(ADC_W'(a)) <= TAC_DISPLAY_MAX) hot_edge = a;
      if (zero_edge < 0 && tracker.tenths_of_adc(ADC_W'(a)) == 0) zero_edge = a;
    end
    send_sample(ADC_W'(0), 1'b1);
    send_sample(ADC_W'(ADC_MAX), 1'b1);
    send_sample(ADC_W'(hot_edge - 1), 1'b1);
    send_sample(ADC_W'(hot_edge), 1'b1);
    send_sample(ADC_W'(zero_edge - 1), 1'b1);
    send_sample(ADC_W'(zero_edge), 1'b1);
    send_sample(10'h2AA, 1'b0);
    send_sample(10'h155, 1'b0);
    send_sample(ADC_W'(600), 1'b1);
    send_sample(ADC_W'(600), 1'b0);   // button is ignored while armed
    send_sample(ADC_W'(1), 1'b1);
    send_sample(ADC_W'(1), 1'b1);
    send_sample(ADC_W'(700), 1'b0);
    send_sample(ADC_W'(700), 1'b0);
    send_sample(ADC_W'(512), 1'b1);
    send_sample(ADC_W'(512), 1'b1);
    // alarm exactly at the threshold
    drain_results();
    write_threshold(tracker.tenths_of_adc(ADC_W'(400)));
    send_sample(ADC_W'(300), 1'b0);
    send_sample(ADC_W'(300), 1'b1);
    send_sample(ADC_W'(401), 1'b1);
    send_sample(ADC_W'(400), 1'b1);
    // zero threshold: even a clamped reading alarms
    drain_results();
    write_threshold('0);
    send_sample(ADC_W'(800), 1'b0);
    send_sample(ADC_W'(800), 1'b1);
    send_sample(ADC_W'(800), 1'b0);
    send_sample(ADC_W'(800), 1'b1);
    send_sample(ADC_W'(ADC_MAX), 1'b1);
    drain_results();
    write_threshold('1);
  endtask

  task automatic run_random(input int count);
    int sent, phase_left, burst_left, gap_max, edge_adc, a;
    int press_left, release_left;
    logic [TAC_TEMP_W-1:0] thr;
    logic btn;
    sent         = 0;
    press_left   = 0;
    release_left = 0;
    while (sent < count) begin
      drain_results();
      case ($urandom_range(0, 5))
        0:       thr = '0;
        1:       thr = '1;
        2:       thr = TAC_THRESHOLD_RST;
        3:       thr = TAC_TEMP_W'($urandom);
        default: thr = tracker.tenths_of_adc(ADC_W'($urandom));
      endcase
      write_threshold(thr);
      edge_adc = ADC_MAX;
      for (int i = ADC_MAX; i >= 0; i--) begin
        if (tracker.tenths_of_adc(ADC_W'(i)) >= thr) begin
          edge_adc = i;
          break;
        end
      end
      phase_left = $urandom_range(80, 250);
      gap_max    = $urandom_range(0, 8);   // zero gives a phase with no sender gaps
      burst_left = $urandom_range(1, 24);
      while (phase_left > 0 && sent < count) begin
        // press/release sequences so the arm and alarm modes are reached often
        if (press_left == 0 && release_left == 0) begin
          press_left   = $urandom_range(1, 3);
          release_left = $urandom_range(1, 8);
        end
        if (press_left > 0) begin
          btn = 1'b0;
          press_left--;
        end else begin
          btn = 1'b1;
          release_left--;
        end
        if ($urandom_range(0, 9) == 0) btn = 1'($urandom);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: a = edge_adc + $urandom_range(0, 16) - 8;
          4, 5, 6:    a = $urandom_range(0, ADC_MAX);
          7:          a = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 2)
                                                      : ADC_MAX - $urandom_range(0, 2);
          default:    a = $urandom_range(300, ADC_MAX);
        endcase
        if (a < 0) a = 0;
        if (a > ADC_MAX) a = ADC_MAX;
        send_sample(ADC_W'(a), btn);
        sent++;
        phase_left--;
        burst_left--;
        if ($urandom_range(0, 149) == 0) begin
          drain_results();
        end else if (burst_left == 0) begin
          if (gap_max > 0) pause_sender($urandom_range(1, gap_max));
          burst_left = $urandom_range(1, 24);
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    run_random(RANDOM_ITEMS);
    drain_results();
    repeat (SETTLE) @(negedge clk);
    if (tracker.pending.size() != 0) begin
      $error("%0d results never arrived", tracker.pending.size());
      tracker.errors++;
    end
    $display("%0d samples checked over %0d threshold writes, %0d alarms raised",
             tracker.reports_checked, thresholds_written, tracker.alarms_raised);
    $display("%0d readings beyond the display range, %0d clamped to zero",
             tracker.saturated, tracker.clamped_cold);
    if (tracker.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
